### hw/rtl/ffws_pkg.sv
// Package for the formation follower wheel speed block.
// Angle constants in 2^-28 rad, arctangent table, CORDIC gain, register indexes.
// No dependencies.
package ffws_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CORDIC_STAGES_MAX = 24;

	localparam int XW = 33;  // vectoring x/y width
	localparam int ZW = 33;  // angle accumulator width
	localparam int CW = 33;  // rotation x/y width
	localparam int SW = 34;  // bearing scaled to 2^-28 rad

	localparam logic signed [ZW-1:0] ANG_PI      = 33'sd843314857;
	localparam logic signed [SW-1:0] ANG_PI_W    = 34'sd843314857;
	localparam logic signed [SW-1:0] ANG_HALF_PI = 34'sd421657428;
	localparam logic signed [SW-1:0] ANG_TWO_PI  = 34'sd1686629713;
	localparam logic signed [17:0]   HALF_PI_Q12 = 18'sd6434;
	localparam logic [29:0]          GAIN_Q30    = 30'd652032874;

	localparam logic [2:0] REG_OFS_X  = 3'd0;
	localparam logic [2:0] REG_OFS_Y  = 3'd1;
	localparam logic [2:0] REG_GAIN_F = 3'd2;
	localparam logic [2:0] REG_GAIN_T = 3'd3;
	localparam logic [2:0] REG_HAXLE  = 3'd4;
	localparam logic [2:0] REG_WSCALE = 3'd5;
	localparam logic [2:0] REG_LIMIT  = 3'd6;
	localparam logic [2:0] REG_WEIGHT = 3'd7;

	localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STAGES_MAX] = '{
		33'sd210828714, 33'sd124459457, 33'sd65760959, 33'sd33381290,
		33'sd16755422, 33'sd8385879, 33'sd4193963, 33'sd2097109,
		33'sd1048571, 33'sd524287, 33'sd262144, 33'sd131072,
		33'sd65536, 33'sd32768, 33'sd16384, 33'sd8192,
		33'sd4096, 33'sd2048, 33'sd1024, 33'sd512,
		33'sd256, 33'sd128, 33'sd64, 33'sd32
	};

endpackage

### hw/rtl/formation_follower_wheel_speeds.sv
// Formation follower wheel speeds: top level.
// Depends on ffws_pkg, ffws_vec_cell, ffws_rot_cell.
//
// Use: each input word on the s_ stream carries the leader position and the
// follower's own pose; each output word on the m_ stream carries the left and
// right wheel speeds for it, in the same order, one result per input word.
// The goal vector is leader - own - slot offset; a row of vectoring CORDIC
// cells gives range and angle, a row of rotation cells gives cos(bearing),
// then a short multiply chain forms forward and turn commands, the wheel
// speeds, the clamp and the follower weight.
// Throughput: one word per cycle while the output is not stalled. The pipe is
// two cell rows plus sixteen fixed stages of arithmetic and multipliers.
// Stall: the whole pipe holds while the output word waits; s_tready falls
// only while a word sits at the output and m_tready is low.
// Config: cfg_valid/cfg_index/cfg_data, always ready; write only while idle.
// Reset (arst_n low): pipe emptied, registers take their default values.
module formation_follower_wheel_speeds #(
	parameter int CORDIC_STAGES = ffws_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// leader_x[19:0], leader_y[39:20], own_x[59:40], own_y[79:60],
	// own_heading[94:80], zero pad[95]
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// left_speed[16:0], right_speed[33:17], zero pad[39:34]
	output logic [39:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	localparam int N = CORDIC_STAGES;
	localparam int L = 2 * N + 16;
	localparam int VSIDE = 16;  // {zero, heading}
	localparam int RSIDE = 43;  // {sign, bearing, range}

	// config registers
	logic signed [17:0] ofs_x_q, ofs_y_q;
	logic [15:0] gain_f_q, gain_t_q, wscale_q;
	logic [14:0] haxle_q;
	logic [11:0] limit_q, weight_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_x_q  <= -18'sd6950;
			ofs_y_q  <= 18'sd6950;
			gain_f_q <= 16'd256;
			gain_t_q <= 16'd256;
			haxle_q  <= 15'd1704;
			wscale_q <= 16'd48780;
			limit_q  <= 12'd1000;
			weight_q <= 12'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				ffws_pkg::REG_OFS_X:  ofs_x_q  <= cfg_data;
				ffws_pkg::REG_OFS_Y:  ofs_y_q  <= cfg_data;
				ffws_pkg::REG_GAIN_F: gain_f_q <= cfg_data[15:0];
				ffws_pkg::REG_GAIN_T: gain_t_q <= cfg_data[15:0];
				ffws_pkg::REG_HAXLE:  haxle_q  <= cfg_data[14:0];
				ffws_pkg::REG_WSCALE: wscale_q <= cfg_data[15:0];
				ffws_pkg::REG_LIMIT:  limit_q  <= cfg_data[11:0];
				ffws_pkg::REG_WEIGHT: weight_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// global advance; valid bits travel alongside the data
	logic adv;
	logic [L-1:0] vld_q;
	assign adv = !vld_q[L-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[L-2:0], s_tvalid};
		end
	end

	// s1: goal vector
	logic signed [21:0] dx_s1, dy_s1;
	logic signed [14:0] hd_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= 22'(signed'(s_tdata[19:0])) - 22'(signed'(s_tdata[59:40]))
				- 22'(ofs_x_q);
			dy_s1 <= 22'(signed'(s_tdata[39:20])) - 22'(signed'(s_tdata[79:60]))
				- 22'(ofs_y_q);
			hd_s1 <= signed'(s_tdata[94:80]);
		end
	end

	// s2: scale by 2^8, fold into the right half-plane
	logic signed [ffws_pkg::XW-1:0] vx [N+1];
	logic signed [ffws_pkg::XW-1:0] vy [N+1];
	logic signed [ffws_pkg::ZW-1:0] vz [N+1];
	logic [VSIDE-1:0] vs [N+1];
	logic signed [ffws_pkg::XW-1:0] sx8, sy8;
	assign sx8 = ffws_pkg::XW'(dx_s1) <<< 8;
	assign sy8 = ffws_pkg::XW'(dy_s1) <<< 8;

	always_ff @(posedge clk) begin
		if (adv) begin
			vs[0] <= {(dx_s1 == '0) && (dy_s1 == '0), hd_s1};
			if (dx_s1 < 0) begin
				vx[0] <= -sx8;
				vy[0] <= -sy8;
				vz[0] <= (dy_s1 >= 0) ? ffws_pkg::ANG_PI : -ffws_pkg::ANG_PI;
			end else begin
				vx[0] <= sx8;
				vy[0] <= sy8;
				vz[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		ffws_vec_cell #(.STAGE(i), .SIDE_W(VSIDE)) u_cell (
			.clk(clk), .en(adv),
			.x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]), .side_in(vs[i]),
			.x_q(vx[i+1]), .y_q(vy[i+1]), .z_q(vz[i+1]), .side_q(vs[i+1])
		);
	end

	// s3: magnitude gain product, angle with zero-vector override
	logic [61:0] mprod_s3;
	logic signed [ffws_pkg::ZW-1:0] ang_s3;
	logic signed [14:0] hd_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			mprod_s3 <= (vx[N] < 0) ? '0 : (62'(vx[N][31:0]) * 62'(ffws_pkg::GAIN_Q30));
			ang_s3   <= vs[N][15] ? '0 : vz[N];
			hd_s3    <= vs[N][14:0];
		end
	end

	// s4: range, bearing
	logic [23:0] range_s4;
	logic signed [17:0] bear_s4;
	logic [62:0] msum;
	logic signed [ffws_pkg::ZW-1:0] angr;
	assign msum = 63'(mprod_s3) + (63'd1 <<< 37);
	assign angr = (ang_s3 + ffws_pkg::ZW'(32768)) >>> 16;
	always_ff @(posedge clk) begin
		if (adv) begin
			range_s4 <= msum[61:38];
			bear_s4  <= 18'(angr) - 18'(hd_s3) - ffws_pkg::HALF_PI_Q12;
		end
	end

	// s5, s6: reduce modulo 2*pi in two steps
	logic signed [ffws_pkg::SW-1:0] a4, a_s5, a_s6;
	logic [23:0] range_s5, range_s6;
	logic signed [17:0] bear_s5, bear_s6;
	assign a4 = ffws_pkg::SW'(bear_s4) <<< 16;
	always_ff @(posedge clk) begin
		if (adv) begin
			range_s5 <= range_s4;
			bear_s5  <= bear_s4;
			if (a4 > ffws_pkg::ANG_PI_W) a_s5 <= a4 - ffws_pkg::ANG_TWO_PI;
			else if (a4 < -ffws_pkg::ANG_PI_W) a_s5 <= a4 + ffws_pkg::ANG_TWO_PI;
			else a_s5 <= a4;
			range_s6 <= range_s5;
			bear_s6  <= bear_s5;
			if (a_s5 > ffws_pkg::ANG_PI_W) a_s6 <= a_s5 - ffws_pkg::ANG_TWO_PI;
			else if (a_s5 < -ffws_pkg::ANG_PI_W) a_s6 <= a_s5 + ffws_pkg::ANG_TWO_PI;
			else a_s6 <= a_s5;
		end
	end

	// s7: fold into +-pi/2, start rotation row
	logic signed [ffws_pkg::CW-1:0] rx [N+1];
	logic signed [ffws_pkg::CW-1:0] ry [N+1];
	logic signed [ffws_pkg::ZW-1:0] rz [N+1];
	logic [RSIDE-1:0] rs [N+1];
	always_ff @(posedge clk) begin
		if (adv) begin
			rx[0] <= ffws_pkg::CW'(ffws_pkg::GAIN_Q30);
			ry[0] <= '0;
			if (a_s6 > ffws_pkg::ANG_HALF_PI) begin
				rz[0] <= ffws_pkg::ZW'(a_s6 - ffws_pkg::ANG_PI_W);
				rs[0] <= {1'b1, bear_s6, range_s6};
			end else if (a_s6 < -ffws_pkg::ANG_HALF_PI) begin
				rz[0] <= ffws_pkg::ZW'(a_s6 + ffws_pkg::ANG_PI_W);
				rs[0] <= {1'b1, bear_s6, range_s6};
			end else begin
				rz[0] <= ffws_pkg::ZW'(a_s6);
				rs[0] <= {1'b0, bear_s6, range_s6};
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		ffws_rot_cell #(.STAGE(i), .SIDE_W(RSIDE)) u_cell (
			.clk(clk), .en(adv),
			.x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]), .side_in(rs[i]),
			.x_q(rx[i+1]), .y_q(ry[i+1]), .z_q(rz[i+1]), .side_q(rs[i+1])
		);
	end

	// s8..s16: commands and wheel speeds
	logic signed [ffws_pkg::CW-1:0] c_s8;
	logic [23:0] range_s8;
	logic signed [17:0] bear_s8;
	logic signed [57:0] rcp_s9;
	logic signed [34:0] w_s9;
	logic signed [57:0] rcp_t;
	logic signed [22:0] rc_s10;
	logic signed [50:0] tp_s10;
	logic signed [39:0] u_s11;
	logic signed [38:0] turn_s11;
	logic signed [40:0] ls_s12, rs_s12;
	logic signed [57:0] lp_s13, rp_s13;
	logic signed [12:0] lv_s14, rv_s14;
	logic signed [25:0] lw_s15, rw_s15;
	logic signed [16:0] lo_s16, ro_s16;

	function automatic logic signed [12:0] clampv(input logic signed [57:0] p,
			input logic [11:0] lim);
		logic [57:0] mag;
		logic signed [34:0] v;
		logic signed [34:0] l;
		begin
			mag = p[57] ? 58'(-p) : 58'(p);
			v = p[57] ? -35'(mag[57:24]) : 35'(mag[57:24]);
			l = 35'(lim);
			if (v > l) clampv = 13'(l);
			else if (v < -l) clampv = 13'(-l);
			else clampv = 13'(v);
		end
	endfunction

	function automatic logic signed [16:0] wtrunc(input logic signed [25:0] p);
		logic [25:0] mag;
		begin
			mag = p[25] ? 26'(-p) : 26'(p);
			wtrunc = p[25] ? -17'(mag[25:8]) : 17'(mag[25:8]);
		end
	endfunction

	assign rcp_t = rcp_s9 + (58'sd1 <<< 29);

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s8     <= rs[N][42] ? -rx[N] : rx[N];
			range_s8 <= rs[N][23:0];
			bear_s8  <= rs[N][41:24];
			rcp_s9   <= 58'(signed'({1'b0, range_s8})) * 58'(c_s8);
			w_s9     <= 35'(signed'({1'b0, gain_t_q})) * 35'(bear_s8);
			rc_s10   <= 23'(rcp_t >>> 30);
			tp_s10   <= 51'(signed'({1'b0, haxle_q})) * 51'(w_s9);
			u_s11    <= 40'(signed'({1'b0, gain_f_q})) * 40'(rc_s10);
			turn_s11 <= 39'(tp_s10 >>> 12);
			ls_s12   <= 41'(u_s11) - 41'(turn_s11);
			rs_s12   <= 41'(u_s11) + 41'(turn_s11);
			lp_s13   <= 58'(ls_s12) * 58'(signed'({1'b0, wscale_q}));
			rp_s13   <= 58'(rs_s12) * 58'(signed'({1'b0, wscale_q}));
			lv_s14   <= clampv(lp_s13, limit_q);
			rv_s14   <= clampv(rp_s13, limit_q);
			lw_s15   <= 26'(lv_s14) * 26'(signed'({1'b0, weight_q}));
			rw_s15   <= 26'(rv_s14) * 26'(signed'({1'b0, weight_q}));
			lo_s16   <= wtrunc(lw_s15);
			ro_s16   <= wtrunc(rw_s15);
		end
	end

	assign m_tdata = {6'b0, ro_s16, lo_s16};

endmodule

### hw/rtl/ffws_vec_cell.sv
// One vectoring CORDIC micro-rotation, registered.
// Depends on ffws_pkg.
module ffws_vec_cell #(
	parameter int STAGE = 0,
	parameter int SIDE_W = 1
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [ffws_pkg::XW-1:0]  x_in,
	input  logic signed [ffws_pkg::XW-1:0]  y_in,
	input  logic signed [ffws_pkg::ZW-1:0]  z_in,
	input  logic        [SIDE_W-1:0]        side_in,
	output logic signed [ffws_pkg::XW-1:0]  x_q,
	output logic signed [ffws_pkg::XW-1:0]  y_q,
	output logic signed [ffws_pkg::ZW-1:0]  z_q,
	output logic        [SIDE_W-1:0]        side_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			if (y_in > 0) begin
				x_q <= x_in + (y_in >>> STAGE);
				y_q <= y_in - (x_in >>> STAGE);
				z_q <= z_in + ffws_pkg::ATAN_TAB[STAGE];
			end else begin
				x_q <= x_in - (y_in >>> STAGE);
				y_q <= y_in + (x_in >>> STAGE);
				z_q <= z_in - ffws_pkg::ATAN_TAB[STAGE];
			end
		end
	end

endmodule

### hw/rtl/ffws_rot_cell.sv
// One rotation-mode CORDIC micro-rotation, registered.
// Depends on ffws_pkg.
module ffws_rot_cell #(
	parameter int STAGE = 0,
	parameter int SIDE_W = 1
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [ffws_pkg::CW-1:0]  x_in,
	input  logic signed [ffws_pkg::CW-1:0]  y_in,
	input  logic signed [ffws_pkg::ZW-1:0]  z_in,
	input  logic        [SIDE_W-1:0]        side_in,
	output logic signed [ffws_pkg::CW-1:0]  x_q,
	output logic signed [ffws_pkg::CW-1:0]  y_q,
	output logic signed [ffws_pkg::ZW-1:0]  z_q,
	output logic        [SIDE_W-1:0]        side_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			if (z_in >= 0) begin
				x_q <= x_in - (y_in >>> STAGE);
				y_q <= y_in + (x_in >>> STAGE);
				z_q <= z_in - ffws_pkg::ATAN_TAB[STAGE];
			end else begin
				x_q <= x_in + (y_in >>> STAGE);
				y_q <= y_in - (x_in >>> STAGE);
				z_q <= z_in + ffws_pkg::ATAN_TAB[STAGE];
			end
		end
	end

endmodule

### tb/sv/formation_follower_wheel_speeds_tb.sv
`timescale 1ns / 100ps
// Testbench for formation_follower_wheel_speeds: stream stimulus, own fixed-point predictor,
// ordered result check. Depends on ffws_pkg and the block's RTL.
module formation_follower_wheel_speeds_tb;

	localparam int STAGES = 16;
	localparam int LATENCY = 2 * STAGES + 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [14:0] heading;
		logic signed [19:0] own_y;
		logic signed [19:0] own_x;
		logic signed [19:0] leader_y;
		logic signed [19:0] leader_x;
	} pose_t;

	typedef struct packed {
		logic signed [16:0] right;
		logic signed [16:0] left;
	} speeds_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = ffws_pkg::REG_OFS_X;
	logic [17:0] cfg_data = '0;

	// formation registers as seen by the predictor
	longint ofs_x, ofs_y, gain_f, gain_t, haxle, wscale, limit, weight;

	speeds_t speeds_due[$];
	int      errors = 0;
	int      idle_cycles = 0;
	bit      sink_hold = 1'b0;   // long receiver hold-off
	bit      sink_busy = 1'b1;   // random stalls allowed
	bit      src_busy = 1'b1;    // random gaps allowed
	int      hold_cycles = 0;

	formation_follower_wheel_speeds #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint trunc_shr(longint v, int s);
		if (v < 0) return -((-v) >>> s);
		return v >>> s;
	endfunction

	function automatic longint atan_step(int i);
		return longint'(ffws_pkg::ATAN_TAB[i]);
	endfunction

	// range (1/65536 m) and atan2 (2^-28 rad) of the goal vector
	task automatic goal_polar(input longint dx, input longint dy,
			output longint rng, output longint ang);
		longint x, y, z, xo;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (dx == 0 && dy == 0) begin
			rng = 0;
			ang = 0;
			return;
		end
		if (x < 0) begin
			z = (y >= 0) ? longint'(ffws_pkg::ANG_PI) : -longint'(ffws_pkg::ANG_PI);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STAGES; i++) begin
			xo = x;
			if (y > 0) begin
				x += floor_shr(y, i);
				y -= floor_shr(xo, i);
				z += atan_step(i);
			end else begin
				x -= floor_shr(y, i);
				y += floor_shr(xo, i);
				z -= atan_step(i);
			end
		end
		if (x < 0) x = 0;
		rng = (x * longint'(ffws_pkg::GAIN_Q30) + (longint'(1) << 37)) >>> 38;
		ang = z;
	endtask

	// cosine in Q1.30, full-turn reduction then quadrant fold
	function automatic longint cos_q30(longint a);
		longint x, y, z, xo, sgn;
		x = longint'(ffws_pkg::GAIN_Q30);
		y = 0;
		sgn = 1;
		while (a > longint'(ffws_pkg::ANG_PI_W)) a -= longint'(ffws_pkg::ANG_TWO_PI);
		while (a < -longint'(ffws_pkg::ANG_PI_W)) a += longint'(ffws_pkg::ANG_TWO_PI);
		if (a > longint'(ffws_pkg::ANG_HALF_PI)) begin
			a -= longint'(ffws_pkg::ANG_PI_W);
			sgn = -1;
		end else if (a < -longint'(ffws_pkg::ANG_HALF_PI)) begin
			a += longint'(ffws_pkg::ANG_PI_W);
			sgn = -1;
		end
		z = a;
		for (int i = 0; i < STAGES; i++) begin
			xo = x;
			if (z >= 0) begin
				x -= floor_shr(y, i);
				y += floor_shr(xo, i);
				z -= atan_step(i);
			end else begin
				x += floor_shr(y, i);
				y -= floor_shr(xo, i);
				z += atan_step(i);
			end
		end
		return sgn * x;
	endfunction

	function automatic longint clamp_and_weigh(longint s);
		longint v;
		v = trunc_shr(s * wscale, 24);
		if (v > limit) v = limit;
		if (v < -limit) v = -limit;
		return trunc_shr(v * weight, 8);
	endfunction

	task automatic predict_wheel_speeds(input pose_t p, output speeds_t r);
		longint dx, dy, rng, ang, bearing, rc, fwd, turn;
		dx = longint'(p.leader_x) - longint'(p.own_x) - ofs_x;
		dy = longint'(p.leader_y) - longint'(p.own_y) - ofs_y;
		goal_polar(dx, dy, rng, ang);
		bearing = floor_shr(ang + 32768, 16) - longint'(p.heading)
			- longint'(ffws_pkg::HALF_PI_Q12);
		rc = floor_shr(rng * cos_q30(bearing * 65536) + (longint'(1) << 29), 30);
		fwd = gain_f * rc;
		turn = floor_shr(haxle * (gain_t * bearing), 12);
		r.left = 17'(clamp_and_weigh(fwd - turn));
		r.right = 17'(clamp_and_weigh(fwd + turn));
	endtask

	// ---------------- drivers ----------------
	// leaves s_tvalid high; drain drops it when the sender stops
	task automatic send_pose(input pose_t p);
		speeds_t r;
		while (src_busy && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {1'b0, p};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_wheel_speeds(p, r);
		speeds_due.push_back(r);
		@(negedge clk);
	endtask

	// register write while idle; out-of-range values are masked as the block does
	task automatic write_reg(input logic [2:0] idx, input longint val);
		cfg_index <= idx;
		cfg_data <= 18'(val);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			ffws_pkg::REG_OFS_X:  ofs_x = longint'($signed(18'(val)));
			ffws_pkg::REG_OFS_Y:  ofs_y = longint'($signed(18'(val)));
			ffws_pkg::REG_GAIN_F: gain_f = val & 16'hFFFF;
			ffws_pkg::REG_GAIN_T: gain_t = val & 16'hFFFF;
			ffws_pkg::REG_HAXLE:  haxle = val & 15'h7FFF;
			ffws_pkg::REG_WSCALE: wscale = val & 16'hFFFF;
			ffws_pkg::REG_LIMIT:  limit = val & 12'hFFF;
			default:    weight = val & 12'hFFF;
		endcase
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (speeds_due.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic set_regs(input longint ox, input longint oy, input longint gf,
			input longint gt, input longint ha, input longint ws, input longint lm,
			input longint wt);
		drain();
		write_reg(ffws_pkg::REG_OFS_X, ox);
		write_reg(ffws_pkg::REG_OFS_Y, oy);
		write_reg(ffws_pkg::REG_GAIN_F, gf);
		write_reg(ffws_pkg::REG_GAIN_T, gt);
		write_reg(ffws_pkg::REG_HAXLE, ha);
		write_reg(ffws_pkg::REG_WSCALE, ws);
		write_reg(ffws_pkg::REG_LIMIT, lm);
		write_reg(ffws_pkg::REG_WEIGHT, wt);
		cfg_valid <= 1'b0;
	endtask

	function automatic pose_t random_pose();
		pose_t p;
		p.leader_x = 20'($urandom);
		p.leader_y = 20'($urandom);
		p.own_x = 20'($urandom);
		p.own_y = 20'($urandom);
		p.heading = 15'($urandom);
		// mostly a nearby leader, so the speeds do not all saturate
		if ($urandom_range(3) != 0) begin
			p.leader_x = p.own_x + 20'($signed($urandom_range(0, 8191)) - 4096);
			p.leader_y = p.own_y + 20'($signed($urandom_range(0, 8191)) - 4096);
			p.heading = 15'($signed($urandom_range(0, 25736)) - 12868);
		end
		return p;
	endfunction

	function automatic pose_t make_pose(longint lx, longint ly, longint ox, longint oy,
			longint hd);
		pose_t p;
		p.leader_x = 20'(lx);
		p.leader_y = 20'(ly);
		p.own_x = 20'(ox);
		p.own_y = 20'(oy);
		p.heading = 15'(hd);
		return p;
	endfunction

	// ---------------- tests ----------------
	task automatic test_directed;
		// zero goal vector at reset offsets
		send_pose(make_pose(-6950, 6950, 0, 0, 0));
		// field extremes
		send_pose(make_pose(524287, 524287, -524288, -524288, 12868));
		send_pose(make_pose(-524288, -524288, 524287, 524287, -12868));
		send_pose(make_pose(524287, -524288, 0, 0, 16383));
		send_pose(make_pose(-524288, 524287, 0, 0, -16384));
		// leader on each axis and in three quadrants around the own position
		send_pose(make_pose(30000, 0, 0, 0, 0));
		send_pose(make_pose(-30000, 0, 0, 0, 0));
		send_pose(make_pose(0, 30000, 0, 0, 20000));
		send_pose(make_pose(0, -30000, 0, 0, -20000));
		send_pose(make_pose(-20000, -5000, 100, 200, 6434));
		send_pose(make_pose(-20000, 5000, -100, 0, -6434));
		send_pose(make_pose(1, 1, 0, 0, 1));
	endtask

	task automatic test_register_extremes;
		set_regs(-65536, 65536, 65535, 65535, 16384, 65535, 4095, 4095);
		repeat (8) send_pose(random_pose());
		set_regs(65536, -65536, 0, 0, 0, 1, 0, 0);
		repeat (4) send_pose(random_pose());
		// wheel scale zero and top bits of ofs_y, gain_f, haxle, limit and weight
		set_regs(131071, -131072, 32768, 1, 32767, 0, 2048, 2048);
		repeat (4) send_pose(random_pose());
		set_regs(0, 0, 256, 256, 1704, 48780, 1000, 256);
		send_pose(make_pose(0, 0, 0, 0, 0));
	endtask

	task automatic test_random_settings;
		for (int ph = 0; ph < 6; ph++) begin
			set_regs($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
				$urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 16384), $urandom_range(1, 65535),
				$urandom_range(0, 4095), $urandom_range(0, 4095));
			repeat (110) send_pose(random_pose());
		end
	endtask

	task automatic test_back_pressure;
		set_regs(-6950, 6950, 256, 256, 1704, 48780, 1000, 256);
		sink_hold = 1'b1;
		repeat (120) send_pose(random_pose());   // fills the pipe, s_tready must drop
		drain();                                  // sender waits for every result
		wait (!sink_hold);
		sink_busy = 1'b0;
		src_busy = 1'b0;
		repeat (150) send_pose(random_pose());   // full rate, no idling
		sink_busy = 1'b1;
		src_busy = 1'b1;
		repeat (80) send_pose(random_pose());
	endtask

	// receiver: random stalls, plus a long hold-off counted here
	always @(negedge clk) begin
		if (sink_hold) begin
			m_tready <= 1'b0;
			hold_cycles++;
			if (hold_cycles >= 300) begin
				sink_hold <= 1'b0;
				hold_cycles = 0;
			end
		end else begin
			m_tready <= !(sink_busy && $urandom_range(99) < 8);
		end
	end

	// result check against the oldest prediction
	always @(posedge clk) begin
		speeds_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[33:0];
			if (speeds_due.size() == 0) begin
				$display("%0t: unexpected word %h", $realtime, m_tdata);
				errors++;
			end else begin
				want = speeds_due.pop_front();
				if (got.left !== want.left) begin
					$display("%0t: left_speed expected %0d actual %0d",
						$realtime, want.left, got.left);
					errors++;
				end
				if (got.right !== want.right) begin
					$display("%0t: right_speed expected %0d actual %0d",
						$realtime, want.right, got.right);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		ofs_x = -6950;
		ofs_y = 6950;
		gain_f = 256;
		gain_t = 256;
		haxle = 1704;
		wscale = 48780;
		limit = 1000;
		weight = 256;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_register_extremes();
		test_random_settings();
		test_back_pressure();
		drain();
		if (errors == 0 && speeds_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
